// File: rtl/core/rhep_pkg.sv
package rhep_pkg;

   localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
   localparam logic [15:0] PROFILE_TWO_MASK = 16'hFFF0;
   localparam logic [15:0] PROFILE_TWO_BYTE = 16'h1000;
   localparam logic [3:0]  ID_STOP          = 4'h0F;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE = 3'd1;
   localparam logic [2:0] ST_EXT_HDR   = 3'd2;
   localparam logic [2:0] ST_EXT_BLOCK = 3'd3;
   localparam logic [2:0] ST_NO_PAYLD  = 3'd4;
   localparam logic [2:0] ST_PAD       = 3'd5;
   localparam logic [2:0] ST_PROFILE   = 3'd6;
   localparam logic [2:0] ST_OVERRUN   = 3'd7;

   localparam logic [1:0] PH_HDR   = 2'd0;
   localparam logic [1:0] PH_VALUE = 2'd1;
   localparam logic [1:0] PH_LEN   = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ext_id;
      logic [11:0] offset;
      logic [11:0] length;
      logic [7:0]  pad_length;
      logic        marker;
      logic [6:0]  pay_type;
      logic [15:0] sequence_res;
      logic [31:0] timestamp;
      logic [31:0] ssrc;
      logic [2:0]  status;
   } rsp_type;

endpackage

// File: rtl/core/rhep_queue.sv
module rhep_queue import rhep_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output req_type pop_data
);

   req_type     mem_ff [4];
   logic [1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == 3'd4);
   assign valid    = (cnt_ff != 3'd0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + 2'(push);
      rd_in  = rd_ff + 2'(pop);
      cnt_in = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/rhep_parser.sv
module rhep_parser import rhep_pkg::*; #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] max_len,
   input  logic        in_valid,
   input  req_type     in_data,
   output logic        in_pop,
   output logic        out_valid,
   output rsp_type     out_data,
   input  logic        out_ready
);

   logic [12:0] pos_ff, pos_in;
   logic [31:0] w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [15:0] prof_ff, prof_in, ew_ff, ew_in;
   logic [1:0]  ph_ff, ph_in;
   logic [8:0]  bl_ff, bl_in;
   logic [7:0]  pid_ff, pid_in;
   logic [2:0]  err_ff, err_in;
   logic        vld_ff, vld_in;
   rsp_type     rsp_ff, rsp_in;

   assign in_pop    = in_valid && (!vld_ff || out_ready);
   assign out_valid = vld_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      logic [12:0] p;
      logic [7:0]  b;
      logic        x;
      logic [6:0]  es;
      logic [18:0] ee, p19, l19, hend, plen, elen;
      logic [2:0]  st;
      logic [7:0]  pad;
      p = pos_ff;
      b = in_data.data_byte;
      pos_in = (pos_ff != 13'h1FFF) ? pos_ff + 13'd1 : pos_ff;
      w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff;
      prof_in = prof_ff; ew_in = ew_ff; ph_in = ph_ff; bl_in = bl_ff;
      pid_in = pid_ff; err_in = err_ff;
      vld_in = vld_ff && !out_ready;
      rsp_in = rsp_ff;
      if (p < 13'd12) begin
         case (p[3:2])
            2'd0: w0_in = {w0_ff[23:0], b};
            2'd1: w1_in = {w1_ff[23:0], b};
            2'd2: w2_in = {w2_ff[23:0], b};
            default: ;
         endcase
      end
      x = w0_in[28];
      es = 7'd12 + {1'b0, w0_in[27:24], 2'b00};
      p19 = {6'd0, p};
      elen = '0;
      if (x && p >= 13'd12) begin
         if (p == 13'(es) || p == 13'(es) + 13'd1)
            prof_in = {prof_ff[7:0], b};
         if (p == 13'(es) + 13'd1 && prof_in != PROFILE_ONE_BYTE
             && (prof_in & PROFILE_TWO_MASK) != PROFILE_TWO_BYTE) begin
            err_in = ST_PROFILE;
            ph_in = PH_DONE;
         end
         if (p == 13'(es) + 13'd2 || p == 13'(es) + 13'd3)
            ew_in = {ew_ff[7:0], b};
      end
      ee = 19'(es) + 19'd4 + {1'b0, ew_in, 2'b00};
      if (x && p >= 13'd12 && p19 >= 19'(es) + 19'd4 && p19 < ee && p <= 13'd4095
          && ph_in != PH_DONE && in_pop) begin
         case (ph_ff)
            PH_VALUE: begin
               bl_in = (bl_ff != 9'd0) ? bl_ff - 9'd1 : bl_ff;
               if (bl_in == 9'd0) ph_in = PH_HDR;
            end
            PH_LEN: begin
               elen = {11'd0, b};
               if (p19 + 19'd1 + elen > ee) begin
                  err_in = ST_OVERRUN;
                  ph_in = PH_DONE;
               end else begin
                  bl_in = {1'b0, b};
                  ph_in = (b == 8'd0) ? PH_HDR : PH_VALUE;
                  rsp_in = '0;
                  rsp_in.ext_id = pid_ff;
                  rsp_in.offset = p[11:0] + 12'd1;
                  rsp_in.length = {4'd0, b};
                  vld_in = 1'b1;
               end
            end
            PH_HDR: begin
               if (prof_in == PROFILE_ONE_BYTE) begin
                  elen = {15'd0, b[3:0]} + 19'd1;
                  if (b[7:4] == ID_STOP) begin
                     ph_in = PH_DONE;
                  end else if (b[7:4] != 4'd0) begin
                     if (p19 + 19'd1 + elen > ee) begin
                        err_in = ST_OVERRUN;
                        ph_in = PH_DONE;
                     end else begin
                        bl_in = elen[8:0];
                        ph_in = PH_VALUE;
                        rsp_in = '0;
                        rsp_in.ext_id = {4'd0, b[7:4]};
                        rsp_in.offset = p[11:0] + 12'd1;
                        rsp_in.length = elen[11:0];
                        vld_in = 1'b1;
                     end
                  end
               end else if (p19 + 19'd1 >= ee) begin
                  ph_in = PH_DONE;
               end else if (b != 8'd0) begin
                  pid_in = b;
                  ph_in = PH_LEN;
               end
            end
            default: ;
         endcase
      end
      l19 = {6'd0, pos_in};
      hend = 19'(es);
      st = ST_OK;
      pad = '0;
      plen = '0;
      if ({4'd0, pos_in} > 17'(max_len) || {4'd0, pos_in} > 17'(MAX_PACKET_BYTES)) begin
         st = ST_TOO_LARGE;
      end else begin
         if (x) begin
            if (l19 < hend + 19'd4) st = ST_EXT_HDR;
            else if (l19 < ee) st = ST_EXT_BLOCK;
            else hend = ee;
         end
         if (st == ST_OK && l19 <= hend) st = ST_NO_PAYLD;
         if (st == ST_OK) begin
            plen = l19 - hend;
            if (w0_in[29]) begin
               pad = b;
               if (b != 8'd0) begin
                  if (plen <= {11'd0, b}) st = ST_PAD;
                  else plen = plen - {11'd0, b};
               end
            end
         end
         if (st == ST_OK && x && err_in != ST_OK) st = err_in;
      end
      if (in_pop) begin
         if (in_data.last_byte) begin
            rsp_in = '0;
            rsp_in.kind = 1'b1;
            if (st == ST_OK) begin
               rsp_in.offset = hend[11:0];
               rsp_in.length = plen[11:0];
               rsp_in.pad_length = pad;
            end
            rsp_in.marker = w0_in[23];
            rsp_in.pay_type = w0_in[22:16];
            rsp_in.sequence_res = w0_in[15:0];
            rsp_in.timestamp = w1_in;
            rsp_in.ssrc = w2_in;
            rsp_in.status = st;
            vld_in = 1'b1;
            pos_in = '0; w0_in = '0; w1_in = '0; w2_in = '0;
            prof_in = '0; ew_in = '0; ph_in = PH_HDR; bl_in = '0;
            pid_in = '0; err_in = ST_OK;
         end
      end else begin
         pos_in = pos_ff; w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff;
         prof_in = prof_ff; ew_in = ew_ff; ph_in = ph_ff; bl_in = bl_ff;
         pid_in = pid_ff; err_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; w0_ff <= '0; w1_ff <= '0; w2_ff <= '0;
         prof_ff <= '0; ew_ff <= '0; ph_ff <= PH_HDR; bl_ff <= '0;
         pid_ff <= '0; err_ff <= ST_OK; vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; w0_ff <= w0_in; w1_ff <= w1_in; w2_ff <= w2_in;
         prof_ff <= prof_in; ew_ff <= ew_in; ph_ff <= ph_in; bl_ff <= bl_in;
         pid_ff <= pid_in; err_ff <= err_in; vld_ff <= vld_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// File: rtl/core/rtp_header_extension_parser_top.sv
// RTP header parser. Takes one packet byte per request with tlast on the final
// byte, and returns one record per header-extension element (tuser 0) as soon
// as its header is seen, plus an end-of-packet summary (tuser 1) with payload
// offset/length, pad length, fixed header fields and status. Sustains one byte
// per cycle while no held result waits on rsp_tready; each byte passes through
// the four-entry input queue, and its result is held in the registered output
// of the parser stage.
// csr_wr_data sets the largest accepted packet length (reset 1500).
module rtp_header_extension_parser_top import rhep_pkg::*; #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // ext_id, offset, length, pad_length, marker,
                                     // pay_type, sequence_res, timestamp, ssrc, status
   output logic         rsp_tuser,   // kind
   input  logic         csr_wr_en,
   input  logic [11:0]  csr_wr_data  // max_packet_len
);

   logic [11:0] max_len_ff;
   logic        q_full, q_valid, q_pop;
   req_type     q_data;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= 12'd1500;
      else if (csr_wr_en) max_len_ff <= csr_wr_data;
   end

   assign req_tready = !q_full;

   rhep_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_tvalid && !q_full),
      .push_data(req_type'{data_byte: req_tdata, last_byte: req_tlast}),
      .full(q_full), .pop(q_pop), .valid(q_valid), .pop_data(q_data)
   );

   rhep_parser #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_parser (
      .clock(clock), .reset(reset), .max_len(max_len_ff),
      .in_valid(q_valid), .in_data(q_data), .in_pop(q_pop),
      .out_valid(rsp_tvalid), .out_data(rsp), .out_ready(rsp_tready)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {5'd0, rsp.status, rsp.ssrc, rsp.timestamp, rsp.sequence_res,
                       rsp.pay_type, rsp.marker, rsp.pad_length, rsp.length,
                       rsp.offset, rsp.ext_id};

endmodule

// File: tb/sv/rtp_header_extension_parser_checker.sv
module rtp_header_extension_parser_checker import rhep_pkg::*; #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [135:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [11:0]  csr_wr_data,
   output int           errors,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type     expected_q[$];
   int unsigned max_len;
   int unsigned pos, prof, ext_words, left, pend_id;
   logic [31:0] hw[3];
   logic [1:0]  phase;
   logic [2:0]  elem_err;

   assign pending = expected_q.size();

   task automatic clear_packet();
      pos = 0; prof = 0; ext_words = 0; left = 0; pend_id = 0;
      hw[0] = '0; hw[1] = '0; hw[2] = '0;
      phase = PH_HDR; elem_err = ST_OK;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      int unsigned p, cc, es, ee, len, hend, plen, pad, id;
      logic        x;
      logic [2:0]  st;
      rsp_type     r;
      bit          got;
      p = pos; got = 0; r = '0;
      if (p < 12) hw[p >> 2] = {hw[p >> 2][23:0], b};
      x  = hw[0][28];
      cc = 32'(hw[0][27:24]);
      es = 12 + 4 * cc;
      if (x && p >= 12) begin
         if (p == es || p == es + 1) prof = ((prof << 8) | b) & 16'hFFFF;
         if (p == es + 1 && prof != PROFILE_ONE_BYTE
             && (prof & PROFILE_TWO_MASK) != PROFILE_TWO_BYTE) begin
            elem_err = ST_PROFILE;
            phase = PH_DONE;
         end
         if (p == es + 2 || p == es + 3) ext_words = ((ext_words << 8) | b) & 16'hFFFF;
         ee = es + 4 + 4 * ext_words;
         if (p >= es + 4 && p < ee && p <= 4095 && phase != PH_DONE) begin
            case (phase)
               PH_VALUE: begin
                  if (left > 0) left--;
                  if (left == 0) phase = PH_HDR;
               end
               PH_LEN: begin
                  if (p + 1 + b > ee) begin
                     elem_err = ST_OVERRUN;
                     phase = PH_DONE;
                  end else begin
                     left = 32'(b);
                     phase = (b == 0) ? PH_HDR : PH_VALUE;
                     r.ext_id = 8'(pend_id); r.offset = 12'(p + 1); r.length = 12'(b);
                     got = 1;
                  end
               end
               default: begin
                  if (prof == PROFILE_ONE_BYTE) begin
                     id = 32'(b[7:4]);
                     if (id == ID_STOP) phase = PH_DONE;
                     else if (id != 0) begin
                        len = 32'(b[3:0]) + 1;
                        if (p + 1 + len > ee) begin
                           elem_err = ST_OVERRUN;
                           phase = PH_DONE;
                        end else begin
                           left = len;
                           phase = PH_VALUE;
                           r.ext_id = 8'(id); r.offset = 12'(p + 1); r.length = 12'(len);
                           got = 1;
                        end
                     end
                  end else if (p + 1 >= ee) phase = PH_DONE;
                  else if (b != 0) begin
                     pend_id = 32'(b);
                     phase = PH_LEN;
                  end
               end
            endcase
         end
      end
      if (pos < 8191) pos++;
      if (last) begin
         len = pos; hend = es; st = ST_OK; plen = 0; pad = 0;
         if (len > max_len || len > MAX_PACKET_BYTES) st = ST_TOO_LARGE;
         else begin
            if (x) begin
               if (len < hend + 4) st = ST_EXT_HDR;
               else if (len < hend + 4 + 4 * ext_words) st = ST_EXT_BLOCK;
               else hend += 4 + 4 * ext_words;
            end
            if (st == ST_OK && len <= hend) st = ST_NO_PAYLD;
            if (st == ST_OK) begin
               plen = len - hend;
               if (hw[0][29]) begin
                  pad = 32'(b);
                  if (pad > 0) begin
                     if (plen <= pad) st = ST_PAD;
                     else plen -= pad;
                  end
               end
            end
            if (st == ST_OK && x && elem_err != ST_OK) st = elem_err;
         end
         r = '0;
         r.kind = 1'b1;
         if (st == ST_OK) begin
            r.offset = 12'(hend); r.length = 12'(plen); r.pad_length = 8'(pad);
         end
         r.marker = hw[0][23];
         r.pay_type = hw[0][22:16];
         r.sequence_res = hw[0][15:0];
         r.timestamp = hw[1];
         r.ssrc = hw[2];
         r.status = st;
         expected_q.push_back(r);
         clear_packet();
      end else if (got) expected_q.push_back(r);
   endtask

   task automatic cmp(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         expected_q.delete();
         max_len = 1500;
         errors = 0;
         clear_packet();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h/%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               e = expected_q.pop_front();
               cmp("kind", 32'(e.kind), 32'(rsp_tuser));
               cmp("ext_id", 32'(e.ext_id), 32'(rsp_tdata[7:0]));
               cmp("offset", 32'(e.offset), 32'(rsp_tdata[19:8]));
               cmp("length", 32'(e.length), 32'(rsp_tdata[31:20]));
               cmp("pad_length", 32'(e.pad_length), 32'(rsp_tdata[39:32]));
               cmp("marker", 32'(e.marker), 32'(rsp_tdata[40]));
               cmp("pay_type", 32'(e.pay_type), 32'(rsp_tdata[47:41]));
               cmp("sequence_res", 32'(e.sequence_res), 32'(rsp_tdata[63:48]));
               cmp("timestamp", e.timestamp, rsp_tdata[95:64]);
               cmp("ssrc", e.ssrc, rsp_tdata[127:96]);
               cmp("status", 32'(e.status), 32'(rsp_tdata[130:128]));
            end
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (csr_wr_en) max_len = 32'(csr_wr_data);
      end
   end

endmodule

// File: tb/sv/rtp_header_extension_parser_top_tb.sv
module rtp_header_extension_parser_top_tb;
   import rhep_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en = 0;
   logic [11:0]  csr_wr_data = '0;
   int           errors, pending;
   int           idle_cycles = 0;
   int           sent = 0;
   bit           hold_rsp = 0;
   bit           rsp_no_idle = 0;
   bit           req_no_idle = 0;
   logic [7:0]   pkt[$];

   always #5 clock = ~clock;

   rtp_header_extension_parser_top DUT (.*);

   rtp_header_extension_parser_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("rtp_header_extension_parser_top_tb: errors");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int g;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
         end
         g = rsp_no_idle ? 0 : $urandom_range(0, 18);
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         if ($urandom_range(0, 60) == 0) rsp_no_idle = !rsp_no_idle;
      end
   end

   task automatic send_packet();
      int g;
      foreach (pkt[i]) begin
         g = req_no_idle ? 0 : $urandom_range(0, 18);
         if (g > 0) begin
            req_tvalid <= 0;
            repeat (g) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata <= pkt[i];
         req_tlast <= (i == pkt.size() - 1);
         do @(posedge clock); while (!req_tready);
         sent++;
      end
   endtask

   task automatic build_packet(input int mode);
      int unsigned cc, w, n, id, l;
      logic [15:0] prof;
      logic        pflag, x;
      logic [7:0]  area[$];
      pkt.delete();
      if (mode == 5) begin
         repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
         return;
      end
      cc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      pflag = (mode == 6) || ($urandom_range(0, 3) == 0);
      x = (mode >= 1 && mode <= 3) || (mode == 4 && $urandom_range(0, 1));
      pkt.push_back({$urandom_range(0, 3) == 0 ? 2'($urandom) : 2'b10, pflag, x, 4'(cc)});
      repeat (11) pkt.push_back(8'($urandom));
      repeat (4 * cc) pkt.push_back(8'($urandom));
      if (x) begin
         case (mode)
            2: prof = PROFILE_TWO_BYTE | 16'($urandom_range(0, 15));
            3: prof = 16'($urandom);
            default: prof = ($urandom_range(0, 1)) ? PROFILE_ONE_BYTE
                            : (PROFILE_TWO_BYTE | 16'($urandom_range(0, 15)));
         endcase
         w = $urandom_range(0, 5);
         pkt.push_back(prof[15:8]); pkt.push_back(prof[7:0]);
         pkt.push_back(8'(w >> 8)); pkt.push_back(8'(w));
         while (area.size() < 4 * w) begin
            if (prof == PROFILE_ONE_BYTE) begin
               n = $urandom_range(0, 19);
               if (n == 0) area.push_back(8'h00);
               else if (n == 1) area.push_back({ID_STOP, 4'($urandom)});
               else begin
                  l = $urandom_range(0, 3);
                  area.push_back({4'($urandom_range(1, 14)), 4'(l)});
                  repeat (l + 1) area.push_back(8'($urandom));
               end
            end else if ($urandom_range(0, 9) == 0) area.push_back(8'h00);
            else begin
               id = $urandom_range(1, 255);
               l = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
               area.push_back(8'(id)); area.push_back(8'(l));
               repeat (l) area.push_back(8'($urandom));
            end
         end
         for (int i = 0; i < 4 * w; i++) pkt.push_back(area[i]);
      end
      n = $urandom_range(0, 20);
      repeat (n) pkt.push_back(8'($urandom));
      if (pflag) pkt.push_back(8'($urandom_range(0, n + 2)));
      if (mode == 4) pkt = pkt[0 : $urandom_range(0, pkt.size() - 1)];
   endtask

   task automatic write_max_len(input logic [11:0] v);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      logic [11:0] settings[5];
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // lone byte, an all-zero header and an all-ones header
      pkt.delete();
      pkt.push_back(8'hFF);
      send_packet();
      pkt.delete();
      repeat (12) pkt.push_back(8'h00);
      send_packet();
      pkt.delete();
      repeat (12) pkt.push_back(8'hFF);
      send_packet();

      settings = '{12'd4095, 12'd12, 12'($urandom_range(13, 200)), 12'd1500, 12'd64};
      for (int ph = 0; ph < 5; ph++) begin
         write_max_len(settings[ph]);
         if (ph == 1) hold_rsp = 1;
         while (sent < 330 * (ph + 1)) begin
            req_no_idle = ($urandom_range(0, 4) == 0);
            if (ph == 1) req_no_idle = 1;
            build_packet($urandom_range(0, 6));
            send_packet();
         end
      end
      req_tvalid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("rtp_header_extension_parser_top_tb: clean");
      else
         $display("rtp_header_extension_parser_top_tb: errors");
      $finish;
   end

endmodule
